// ----- design/hla_pkg.sv -----
// ----------------------------------------------------------------------------
// hla_pkg: shared types and constants for the HSL lightness adjust block
// Register indexes of the configuration port and the divider stage record.
// ----------------------------------------------------------------------------
package hla_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET = 2'd2;

   localparam logic [CSR_DATA_W-1:0] GAIN_RESET = 16'd4096;

   // one divider stage: per channel partial remainder, dividend bits still to
   // shift in, quotient so far and saturation; shared divisor and gray path
   typedef struct packed {
      logic [2:0][8:0] rem;
      logic [2:0][7:0] lo;
      logic [2:0][7:0] quo;
      logic [2:0]      sat;
      logic [7:0]      dvs;
      logic            gray;
      logic [7:0]      gval;
   } div_stage_type;

endpackage

// ----- design/hla_div_stage.sv -----
// ----------------------------------------------------------------------------
// hla_div_stage: two restoring division steps for three channels
// Registered stage of the channel divider; advances when enable is high.
// ----------------------------------------------------------------------------
module hla_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  hla_pkg::div_stage_type in_data,
   output logic                  out_valid,
   output hla_pkg::div_stage_type out_data
);

   hla_pkg::div_stage_type data_in;
   hla_pkg::div_stage_type data_ff;
   logic                   valid_ff;
   logic [8:0]             rem_sh;

   // shift in one dividend bit, subtract divisor when it fits
   always_comb begin
      data_in = in_data;
      rem_sh  = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            rem_sh         = {data_in.rem[i][7:0], data_in.lo[i][7]};
            data_in.lo[i]  = {data_in.lo[i][6:0], 1'b0};
            if (rem_sh >= {1'b0, data_in.dvs}) begin
               data_in.rem[i] = rem_sh - {1'b0, data_in.dvs};
               data_in.quo[i] = {data_in.quo[i][6:0], 1'b1};
            end else begin
               data_in.rem[i] = rem_sh;
               data_in.quo[i] = {data_in.quo[i][6:0], 1'b0};
            end
         end
      end
   end

   // hold or advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // partial remainder stays below the divisor on unsaturated channels
   a_rem0: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.sat[0] |-> data_ff.rem[0] < {1'b0, data_ff.dvs})
      else $error("channel 0 remainder not below divisor");
   a_rem1: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.sat[1] |-> data_ff.rem[1] < {1'b0, data_ff.dvs})
      else $error("channel 1 remainder not below divisor");
   a_rem2: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.sat[2] |-> data_ff.rem[2] < {1'b0, data_ff.dvs})
      else $error("channel 2 remainder not below divisor");

endmodule

// ----- design/hsl_lightness_adjust.sv -----
// ----------------------------------------------------------------------------
// hsl_lightness_adjust: change HSL lightness of a 24-bit color
// Keeps hue and saturation; gain or offset mode; ten-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the receiver takes results; the
// pipeline is five arithmetic stages, four divider stages (two quotient
// bits per stage) and an output register.
// Stalls back up stage by stage; empty stages keep accepting.
// Reset clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module hsl_lightness_adjust #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_pixel_out,
   input  logic        csr_we,
   input  logic [hla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hla_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int F   = GAIN_FRAC_BITS;
   localparam int SQW = F + 9;
   localparam int DQW = F + 8;
   localparam int PW  = F + 17;
   localparam int QW  = F + 19;
   localparam int SW  = F + 20;
   localparam logic [SQW-1:0] SQ_MAX = SQW'(510) << F;
   localparam logic [SQW-1:0] DQ_MID = SQW'(255) << F;

   // configuration registers
   logic              mode_ff;
   logic [15:0]       gain_ff;
   logic signed [8:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         gain_ff   <= hla_pkg::GAIN_RESET;
         offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hla_pkg::REG_MODE:   mode_ff   <= csr_wdata[0];
            hla_pkg::REG_GAIN:   gain_ff   <= csr_wdata;
            hla_pkg::REG_OFFSET: offset_ff <= $signed(csr_wdata[8:0]);
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when the next one loads
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic en1, en2, en3, en4, en5, en_o;
   logic [4:0] div_valid;
   logic [3:0] div_en;
   hla_pkg::div_stage_type div_data [5];

   assign en_o      = !vo_ff || rsp_ready;
   assign div_en[3] = !div_valid[4] || en_o;
   assign div_en[2] = !div_valid[3] || div_en[3];
   assign div_en[1] = !div_valid[2] || div_en[2];
   assign div_en[0] = !div_valid[1] || div_en[1];
   assign en5       = !v5_ff || div_en[0];
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1)  v1_ff <= req_valid;
         if (en2)  v2_ff <= v1_ff;
         if (en3)  v3_ff <= v2_ff;
         if (en4)  v4_ff <= v3_ff;
         if (en5)  v5_ff <= v4_ff;
         if (en_o) vo_ff <= div_valid[4];
      end
   end

   // stage 1: max, min, lightness sum, distance to nearest bound, offsets
   logic [2:0][7:0] ch;
   logic [7:0]      mx, mn, cr;
   logic [8:0]      s_in;
   logic [7:0]      d_in;
   logic [2:0][9:0] k_in;
   logic [8:0]      s1_ff;
   logic [7:0]      d1_ff, mx1_ff;
   logic [2:0][9:0] k1_ff;
   logic            gray1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch[i] = req_pixel_in[8*i +: 8];
      end
      mx = ch[0];
      mn = ch[0];
      for (int i = 1; i < 3; i++) begin
         if (ch[i] > mx) mx = ch[i];
         if (ch[i] < mn) mn = ch[i];
      end
      cr   = mx - mn;
      s_in = {1'b0, mx} + {1'b0, mn};
      d_in = (s_in > 9'd255) ? 8'(9'd510 - s_in) : s_in[7:0];
      for (int i = 0; i < 3; i++) begin
         k_in[i] = {1'b0, 8'(ch[i] - mn), 1'b0} - {2'b00, cr};
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff    <= s_in;
         d1_ff    <= d_in;
         mx1_ff   <= mx;
         k1_ff    <= k_in;
         gray1_ff <= (mx == mn);
      end
   end

   // stage 2: new lightness sum and gray result
   logic [24:0]        gain_prod;
   logic [SQW-1:0]     sq_gain, sq_off;
   logic signed [10:0] t_sum;
   logic [8:0]         t_clamp;
   logic [24:0]        gray_sum;
   logic [24:0]        gray_sh;
   logic [7:0]         gx_gain;
   logic [SQW-1:0]     sq2_ff;
   logic [7:0]         gx2_ff, d2_ff;
   logic [2:0][9:0]    k2_ff;
   logic               gray2_ff;

   always_comb begin
      gain_prod = 25'(s1_ff) * 25'(gain_ff);
      sq_gain   = (gain_prod > 25'(SQ_MAX)) ? SQ_MAX : gain_prod[SQW-1:0];
      t_sum     = $signed({2'b00, s1_ff}) + $signed({offset_ff[8], offset_ff, 1'b0});
      if (t_sum < 0) begin
         t_clamp = 9'd0;
      end else if (t_sum > 11'sd510) begin
         t_clamp = 9'd510;
      end else begin
         t_clamp = t_sum[8:0];
      end
      sq_off   = SQW'(t_clamp) << F;
      gray_sum = 25'(mx1_ff) * 25'(gain_ff) + (25'(1) << (F - 1));
      gray_sh  = gray_sum >> F;
      gx_gain  = (gray_sh > 25'd255) ? 8'hFF : gray_sh[7:0];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sq2_ff   <= mode_ff ? sq_off : sq_gain;
         gx2_ff   <= mode_ff ? t_clamp[8:1] : gx_gain;
         d2_ff    <= d1_ff;
         k2_ff    <= k1_ff;
         gray2_ff <= gray1_ff;
      end
   end

   // stage 3: distance of new sum to nearest bound
   logic [DQW-1:0]  dq3_ff;
   logic [SQW-1:0]  sq3_ff;
   logic [7:0]      gx3_ff, d3_ff;
   logic [2:0][9:0] k3_ff;
   logic            gray3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         dq3_ff   <= (sq2_ff > DQ_MID) ? DQW'(SQ_MAX - sq2_ff) : sq2_ff[DQW-1:0];
         sq3_ff   <= sq2_ff;
         gx3_ff   <= gx2_ff;
         d3_ff    <= d2_ff;
         k3_ff    <= k2_ff;
         gray3_ff <= gray2_ff;
      end
   end

   // stage 4: products of the channel numerator
   logic [PW-1:0]        p4_ff;
   logic signed [QW-1:0] q4_ff [3];
   logic [7:0]           gx4_ff, d4_ff;
   logic                 gray4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         p4_ff <= PW'(sq3_ff) * PW'(d3_ff);
         for (int i = 0; i < 3; i++) begin
            q4_ff[i] <= QW'($signed({1'b0, dq3_ff})) * QW'($signed(k3_ff[i]));
         end
         gx4_ff   <= gx3_ff;
         d4_ff    <= d3_ff;
         gray4_ff <= gray3_ff;
      end
   end

   // stage 5: add rounding term, drop fraction bits
   logic signed [SW-1:0] num [3];
   logic [17:0]          n5_ff [3];
   logic [7:0]           gx5_ff, d5_ff;
   logic                 gray5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = $signed(SW'(p4_ff)) + SW'(q4_ff[i]) + $signed(SW'(d4_ff) << F);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         for (int i = 0; i < 3; i++) begin
            n5_ff[i] <= num[i][F+18:F+1];
         end
         gx5_ff   <= gx4_ff;
         d5_ff    <= d4_ff;
         gray5_ff <= gray4_ff;
      end
   end

   // divider setup: saturate when the quotient would exceed eight bits
   always_comb begin
      div_data[0] = '0;
      for (int i = 0; i < 3; i++) begin
         div_data[0].sat[i] = n5_ff[i][17:8] >= {2'b00, d5_ff};
         div_data[0].rem[i] = {1'b0, n5_ff[i][15:8]};
         div_data[0].lo[i]  = n5_ff[i][7:0];
      end
      div_data[0].dvs  = d5_ff;
      div_data[0].gray = gray5_ff;
      div_data[0].gval = gx5_ff;
   end
   assign div_valid[0] = v5_ff;

   // stages 6 to 9: channel divider
   for (genvar g = 0; g < 4; g++) begin : g_div
      hla_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .enable    (div_en[g]),
         .in_valid  (div_valid[g]),
         .in_data   (div_data[g]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   // output register: pick gray, saturated or divided channel
   logic [23:0] out_in;
   logic [23:0] out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_data[4].gray) begin
            out_in[8*i +: 8] = div_data[4].gval;
         end else if (div_data[4].sat[i]) begin
            out_in[8*i +: 8] = 8'hFF;
         end else begin
            out_in[8*i +: 8] = div_data[4].quo[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_pixel_out = out_ff;

   // input stalls only when every stage is full and the result is held
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vo_ff && !rsp_ready && v1_ff && v5_ff && (&div_valid[4:1]))
      else $error("input stalled with an empty stage");
   a_sq: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> sq2_ff <= SQ_MAX)
      else $error("new lightness sum above white");
   a_dq: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> {1'b0, dq3_ff} <= DQ_MID)
      else $error("bound distance above half range");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for hsl_lightness_adjust
// Streams colors through the block under several gain and offset settings,
// predicts each adjusted color in exact integer arithmetic and compares every
// result transfer in order. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC       = 12;
   localparam int WATCH_MAX  = 20000;
   localparam int DRAIN_WAIT = 40;

   // index past the register list, written to check that it is ignored
   localparam logic [hla_pkg::CSR_INDEX_W-1:0] REG_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [23:0] req_pixel_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [23:0] rsp_pixel_out;
   logic        csr_we;
   logic [hla_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hla_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // predictor copy of the registers
   logic              mode_q;
   logic [15:0]       gain_q;
   logic signed [8:0] offset_q;

   logic [23:0] pending_pixels[$];
   logic [23:0] expected_pixels[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatch_count;
   int          watch_count;
   bit          stim_done;

   hsl_lightness_adjust #(.GAIN_FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pixel_out(rsp_pixel_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint unsigned div_round(longint unsigned num,
                                                 longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // compute the color with its lightness changed
   function automatic logic [23:0] adjust_lightness(logic [23:0] px);
      longint unsigned one;
      longint unsigned ch[3];
      longint unsigned mx, mn, s, c, d, sq, dq, x, num, v;
      longint          t;
      logic [23:0]     res;
      one = 64'd1 << FRAC;
      res = '0;
      for (int i = 0; i < 3; i++) ch[i] = px[8*i +: 8];
      mx = ch[0];
      mn = ch[0];
      for (int i = 1; i < 3; i++) begin
         if (ch[i] > mx) mx = ch[i];
         if (ch[i] < mn) mn = ch[i];
      end
      s = mx + mn;
      if (mode_q) begin
         t = longint'(s) + 2 * longint'(offset_q);
         if (t < 0) t = 0;
         if (t > 510) t = 510;
         sq = longint'(t) * one;
      end else begin
         sq = s * gain_q;
         if (sq > 510 * one) sq = 510 * one;
      end
      // gray: scale or shift the level directly
      if (mx == mn) begin
         if (mode_q) x = sq / (2 * one);
         else begin
            x = div_round(mx * gain_q, one);
            if (x > 255) x = 255;
         end
         return {x[7:0], x[7:0], x[7:0]};
      end
      c = mx - mn;
      d = (s > 255) ? 510 - s : s;
      dq = (sq > 255 * one) ? 510 * one - sq : sq;
      for (int i = 0; i < 3; i++) begin
         num = sq * d + 2 * dq * (ch[i] - mn) - dq * c;
         v = div_round(num, 2 * d * one);
         if (v > 255) v = 255;
         res[8*i +: 8] = v[7:0];
      end
      return res;
   endfunction

   // driver: present pending colors, advance on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_pixel_in <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on input transfer, check on result transfer
   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         rsp_ready   <= 1'b0;
         watch_count <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (req_valid && req_ready)
            expected_pixels.push_back(adjust_lightness(req_pixel_in));
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result pixel_out=%h", rsp_pixel_out);
            end else begin
               want = expected_pixels.pop_front();
               if (want !== rsp_pixel_out) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("pixel_out mismatch: expected %h actual %h",
                              want, rsp_pixel_out);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) watch_count <= 0;
         else watch_count <= watch_count + 1;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (!stim_done && watch_count >= WATCH_MAX) begin
         $display("timeout with %0d results outstanding", expected_pixels.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // sample on the falling edge, after all clocked updates have settled
   task automatic wait_drained();
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [hla_pkg::CSR_INDEX_W-1:0] idx,
                            logic [hla_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == hla_pkg::REG_MODE) mode_q = val[0];
      else if (idx == hla_pkg::REG_GAIN) gain_q = val;
      else if (idx == hla_pkg::REG_OFFSET) offset_q = val[8:0];
   endtask

   function automatic logic [23:0] random_color();
      logic [7:0] base;
      base = 8'($urandom_range(255));
      case ($urandom_range(5))
         0: return {3{base}};
         1: return {base, $urandom_range(255) > 127 ? 8'd255 : 8'd0, base};
         default: return 24'($urandom_range(24'hFFFFFF));
      endcase
   endfunction

   task automatic run_phase(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) pending_pixels.push_back(random_color());
      wait_drained();
   endtask

   initial begin
      logic [23:0] corner[$];
      mode_q         = 1'b0;
      gain_q         = hla_pkg::GAIN_RESET;
      offset_q       = '0;
      mismatch_count = 0;
      stim_done      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_in   = '0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: black, white, grays, primaries, near-extreme lightness
      corner = {24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'h0000FF,
                24'h00FF00, 24'hFF0000, 24'hFF00FF, 24'h00FFFF, 24'h0180FE,
                24'h010000, 24'hFFFEFF, 24'h123456, 24'hAA5533, 24'h554433};
      foreach (corner[i]) pending_pixels.push_back(corner[i]);
      wait_drained();
      write_reg(hla_pkg::REG_GAIN, 16'hFFFF);
      foreach (corner[i]) pending_pixels.push_back(corner[i]);
      wait_drained();
      write_reg(hla_pkg::REG_MODE, 16'd1);
      write_reg(hla_pkg::REG_OFFSET, 16'h100);
      foreach (corner[i]) pending_pixels.push_back(corner[i]);
      wait_drained();
      write_reg(hla_pkg::REG_OFFSET, 16'd255);
      foreach (corner[i]) pending_pixels.push_back(corner[i]);
      wait_drained();
      write_reg(REG_NONE, 16'hFFFF);

      // random phases over several settings and idling patterns
      for (int p = 0; p < 8; p++) begin
         write_reg(hla_pkg::REG_MODE, {15'd0, p[0]});
         case (p)
            0: write_reg(hla_pkg::REG_GAIN, 16'd0);
            2: write_reg(hla_pkg::REG_GAIN, 16'($urandom_range(8192)));
            4: write_reg(hla_pkg::REG_GAIN, 16'($urandom_range(65535)));
            6: write_reg(hla_pkg::REG_GAIN, 16'd4096);
            default: write_reg(hla_pkg::REG_OFFSET, 16'($urandom_range(511)));
         endcase
         if (p == 3) write_reg(hla_pkg::REG_OFFSET, 16'h101);
         run_phase(110, (p % 4 == 1) ? 67 : (p % 4 == 3) ? 31 : 0,
                   (p % 4 == 2) ? 67 : (p % 4 == 3) ? 31 : 0);
      end
      run_phase(60, 31, 67);

      stim_done = 1'b1;
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
